// ===== design/smi_pkg.sv =====
// Shared types and constants for the small matrix inverse core.
package smi_pkg;

  // Element format and derived arithmetic widths.
  localparam int DW      = 32;            // element width
  localparam int FB      = 16;            // fraction bits of an element
  localparam int NELEM   = 9;             // elements of a 3x3 matrix
  localparam int EIW     = 4;             // bits of an element index
  localparam int PW      = 2 * DW;        // product of two elements
  localparam int AW      = 2 * DW + 1;    // adjugate entry
  localparam int TW      = 2 * DW + 1;    // element times half an adjugate entry
  localparam int SW      = 2 * DW + 3;    // sum of three such products
  localparam int DLW     = 3 * DW + 3;    // exact determinant
  localparam int NW      = AW + 2 * FB;   // scaled adjugate magnitude
  localparam int RW      = ((NW > DLW + DW) ? NW : DLW + DW) + 1;  // divider remainder
  localparam int DETW    = 64;            // determinant output
  localparam int DIV_LAT = DW + 1;        // register stages of one divider lane

  // Queue between the front and the back.
  localparam int QDEPTH  = 4;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  // Size selector codes.
  localparam logic MODE_2X2 = 1'b0;
  localparam logic MODE_3X3 = 1'b1;

  typedef logic signed [DW-1:0] elem_t;

  typedef struct packed {
    logic  action;
    elem_t m_e0;
    elem_t m_e1;
    elem_t m_e2;
    elem_t m_e3;
    elem_t m_e4;
    elem_t m_e5;
    elem_t m_e6;
    elem_t m_e7;
    elem_t m_e8;
  } mat_t;

  typedef struct packed {
    elem_t                  inv_e0;
    elem_t                  inv_e1;
    elem_t                  inv_e2;
    elem_t                  inv_e3;
    elem_t                  inv_e4;
    elem_t                  inv_e5;
    elem_t                  inv_e6;
    elem_t                  inv_e7;
    elem_t                  inv_e8;
    logic signed [DETW-1:0] determinant;
    logic                   singular;
  } res_t;

  // Classified work item: size flag and elements, unused ones cleared.
  typedef struct packed {
    logic                       three;
    logic [NELEM-1:0][DW-1:0]   e;
  } work_t;

endpackage

// ===== design/smi_front.sv =====
// Front part: accepts matrices, classifies them and queues them for the back part.
module smi_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           mat_valid,
  output logic           mat_stall,
  input  smi_pkg::mat_t  mat,
  output smi_pkg::work_t head,
  output logic           head_valid,
  input  logic           pop
);

  localparam int QCW = smi_pkg::QCW;
  localparam int QAW = smi_pkg::QAW;

  logic [QCW-1:0]  count;
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  smi_pkg::work_t  slots [smi_pkg::QDEPTH];
  smi_pkg::work_t  item;
  logic            push;

  // Stall only on a full queue, so the stall never looks at valid.
  assign mat_stall  = (count == QCW'(smi_pkg::QDEPTH));
  assign push       = mat_valid && !mat_stall;
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Classify the transaction; a 2x2 matrix leaves the lower elements cleared.
  always_comb begin
    item.three = (mat.action == smi_pkg::MODE_3X3);
    item.e[0]  = mat.m_e0;
    item.e[1]  = mat.m_e1;
    item.e[2]  = mat.m_e2;
    item.e[3]  = mat.m_e3;
    item.e[4]  = mat.m_e4;
    item.e[5]  = mat.m_e5;
    item.e[6]  = mat.m_e6;
    item.e[7]  = mat.m_e7;
    item.e[8]  = mat.m_e8;
    if (!item.three) begin
      for (int k = 4; k < smi_pkg::NELEM; k++) begin
        item.e[k] = '0;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // The back part never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");

  // The fill count stays within the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(smi_pkg::QDEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== design/smi_div_lane.sv =====
// One pipelined saturating divider lane, one quotient bit per stage.
module smi_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [smi_pkg::NW-1:0]     n_abs,
  input  logic [smi_pkg::DLW-1:0]    d_abs,
  input  logic                       neg,
  input  logic                       zero,
  output smi_pkg::elem_t             quot
);

  localparam int DW  = smi_pkg::DW;
  localparam int RW  = smi_pkg::RW;
  localparam int DLW = smi_pkg::DLW;

  localparam smi_pkg::elem_t QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam smi_pkg::elem_t QMIN = {1'b1, {(DW-1){1'b0}}};

  logic [RW-1:0]  rem  [0:DW-1];
  logic [DLW-1:0] den  [0:DW-1];
  logic [DW-1:0]  qb   [0:DW];
  logic           ovf  [0:DW];
  logic           sgn  [0:DW];
  logic           zro  [0:DW];
  logic [RW-1:0]  dsh  [1:DW];
  logic           fits [1:DW];

  // Trial subtraction of each stage against the divisor shifted to its bit.
  always_comb begin
    for (int k = 1; k <= DW; k++) begin
      dsh[k]  = RW'(den[k-1]) << (DW - k);
      fits[k] = (rem[k-1] >= dsh[k]);
    end
  end

  // Stage registers; stage zero also flags quotients of more than DW bits.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(n_abs);
      den[0] <= d_abs;
      qb[0]  <= '0;
      ovf[0] <= (RW'(n_abs) >= (RW'(d_abs) << DW));
      sgn[0] <= neg;
      zro[0] <= zero;
      for (int k = 1; k < DW; k++) begin
        rem[k] <= fits[k] ? (rem[k-1] - dsh[k]) : rem[k-1];
        den[k] <= den[k-1];
      end
      for (int k = 1; k <= DW; k++) begin
        qb[k]  <= qb[k-1] | (DW'(fits[k]) << (DW - k));
        ovf[k] <= ovf[k-1];
        sgn[k] <= sgn[k-1];
        zro[k] <= zro[k-1];
      end
    end
  end

  // Apply the sign and saturate to the element range; a set zero flag gives zero.
  always_comb begin
    if (zro[DW]) begin
      quot = '0;
    end else if (ovf[DW]) begin
      quot = sgn[DW] ? QMIN : QMAX;
    end else if (sgn[DW]) begin
      quot = qb[DW][DW-1] ? QMIN : smi_pkg::elem_t'(-qb[DW]);
    end else begin
      quot = qb[DW][DW-1] ? QMAX : smi_pkg::elem_t'(qb[DW]);
    end
  end

endmodule

// ===== design/smi_back.sv =====
// Back part: adjugate, determinant, nine divider lanes and the result register.
module smi_back (
  input  logic           clk,
  input  logic           rst,
  input  smi_pkg::work_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output smi_pkg::res_t  res
);

  localparam int DW   = smi_pkg::DW;
  localparam int FB   = smi_pkg::FB;
  localparam int PW   = smi_pkg::PW;
  localparam int AW   = smi_pkg::AW;
  localparam int TW   = smi_pkg::TW;
  localparam int SW   = smi_pkg::SW;
  localparam int DLW  = smi_pkg::DLW;
  localparam int NW   = smi_pkg::NW;
  localparam int DETW = smi_pkg::DETW;
  localparam int LAT  = smi_pkg::DIV_LAT;
  localparam int EIW  = smi_pkg::EIW;

  // Cofactor operand indexes: adj[k] = e[AL]*e[AR] - e[BL]*e[BR].
  localparam int unsigned AL [9] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
  localparam int unsigned AR [9] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
  localparam int unsigned BL [9] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
  localparam int unsigned BR [9] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

  localparam logic signed [DETW-1:0] DMAX = {1'b0, {(DETW-1){1'b1}}};
  localparam logic signed [DETW-1:0] DMIN = {1'b1, {(DETW-1){1'b0}}};

  logic en;

  // Stage 1: cofactor products.
  smi_pkg::elem_t        ol [9];
  smi_pkg::elem_t        orr [9];
  smi_pkg::elem_t        bl [9];
  smi_pkg::elem_t        br [9];
  logic                  s1_v;
  logic                  s1_three;
  smi_pkg::elem_t        s1_e [3];
  smi_pkg::elem_t        s1_e3;
  logic signed [PW-1:0]  s1_pa [9];
  logic signed [PW-1:0]  s1_pb [9];

  // Stage 2: adjugate and the 2x2 determinant.
  logic signed [AW-1:0]  adj_c [9];
  logic                  s2_v;
  logic                  s2_three;
  smi_pkg::elem_t        s2_e [3];
  logic signed [AW-1:0]  s2_adj [9];
  logic signed [DLW-1:0] s2_det2;

  // Stage 3: split products of the first row against the first column.
  logic                  s3_v;
  logic                  s3_three;
  logic signed [AW-1:0]  s3_adj [9];
  logic signed [DLW-1:0] s3_det2;
  logic signed [TW-1:0]  s3_thi [3];
  logic signed [TW-1:0]  s3_tlo [3];

  // Stage 4: partial sums.
  logic                  s4_v;
  logic                  s4_three;
  logic signed [AW-1:0]  s4_adj [9];
  logic signed [DLW-1:0] s4_det2;
  logic signed [SW-1:0]  s4_shi;
  logic signed [SW-1:0]  s4_slo;

  // Stage 5: exact determinant.
  logic                  s5_v;
  logic                  s5_three;
  logic signed [AW-1:0]  s5_adj [9];
  logic signed [DLW-1:0] s5_det;

  // Stage 6: magnitudes and signs for the dividers.
  logic [AW-1:0]         adj_abs [9];
  logic signed [DLW-1:0] det_scaled;
  logic                  s6_v;
  logic [NW-1:0]         s6_n [9];
  logic [DLW-1:0]        s6_d;
  logic                  s6_neg [9];
  logic                  s6_sing;
  logic signed [DETW-1:0] s6_det;

  // Divider stages and the side line that travels with them.
  smi_pkg::elem_t        quot [9];
  logic                  side_v    [LAT];
  logic                  side_sing [LAT];
  logic signed [DETW-1:0] side_det [LAT];
  smi_pkg::res_t         res_d;

  // Saturate an exact value to the determinant output range.
  function automatic logic signed [DETW-1:0] sat_det(input logic signed [DLW-1:0] x);
    logic [DLW-DETW:0] top;
    top = x[DLW-1:DETW-1];
    if ((&top) || !(|top)) begin
      return x[DETW-1:0];
    end
    return x[DLW-1] ? DMIN : DMAX;
  endfunction

  // The whole pipeline moves unless a finished result is held by the sink.
  assign en  = !res_valid || !res_stall;
  assign pop = en && head_valid;

  // Operand selection; a 2x2 matrix puts its determinant on the last lane.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ol[k]  = head.e[EIW'(AL[k])];
      orr[k] = head.e[EIW'(AR[k])];
      bl[k]  = head.e[EIW'(BL[k])];
      br[k]  = head.e[EIW'(BR[k])];
    end
    if (!head.three) begin
      orr[8] = head.e[3];
      bl[8]  = head.e[2];
      br[8]  = head.e[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_three <= head.three;
      s1_e[0]  <= head.e[0];
      s1_e[1]  <= head.e[1];
      s1_e[2]  <= head.e[2];
      s1_e3    <= head.e[3];
      for (int k = 0; k < 9; k++) begin
        s1_pa[k] <= ol[k] * orr[k];
        s1_pb[k] <= bl[k] * br[k];
      end
    end
  end

  // Adjugate entries; the 2x2 adjugate comes straight from the elements.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      adj_c[k] = AW'(s1_pa[k]) - AW'(s1_pb[k]);
    end
    if (!s1_three) begin
      for (int k = 0; k < 9; k++) begin
        adj_c[k] = '0;
      end
      adj_c[0] = AW'(s1_e3);
      adj_c[1] = -AW'(s1_e[1]);
      adj_c[2] = -AW'(s1_e[2]);
      adj_c[3] = AW'(s1_e[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_three <= s1_three;
      s2_e     <= s1_e;
      s2_adj   <= adj_c;
      s2_det2  <= DLW'(s1_pa[8]) - DLW'(s1_pb[8]);
    end
  end

  // Each first-row element times the upper and lower half of its cofactor.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_three <= s2_three;
      s3_adj   <= s2_adj;
      s3_det2  <= s2_det2;
      for (int j = 0; j < 3; j++) begin
        s3_thi[j] <= s2_e[j] * $signed(s2_adj[3*j][AW-1:DW]);
        s3_tlo[j] <= s2_e[j] * $signed({1'b0, s2_adj[3*j][DW-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_three <= s3_three;
      s4_adj   <= s3_adj;
      s4_det2  <= s3_det2;
      s4_shi   <= SW'(s3_thi[0]) + SW'(s3_thi[1]) + SW'(s3_thi[2]);
      s4_slo   <= SW'(s3_tlo[0]) + SW'(s3_tlo[1]) + SW'(s3_tlo[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_three <= s4_three;
      s5_adj   <= s4_adj;
      s5_det   <= s4_three ? ((DLW'(s4_shi) <<< DW) + DLW'(s4_slo)) : s4_det2;
    end
  end

  // Magnitudes, quotient signs and the rounded determinant.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      adj_abs[k] = s5_adj[k][AW-1] ? AW'(-s5_adj[k]) : AW'(s5_adj[k]);
    end
    det_scaled = s5_three ? (s5_det >>> FB) : s5_det;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        s6_n[k]   <= {adj_abs[k], {(2*FB){1'b0}}};
        s6_neg[k] <= s5_adj[k][AW-1] ^ s5_det[DLW-1];
      end
      s6_d    <= s5_det[DLW-1] ? DLW'(-s5_det) : DLW'(s5_det);
      s6_sing <= (s5_det == '0);
      s6_det  <= sat_det(det_scaled);
    end
  end

  // Nine divider lanes share the determinant.
  for (genvar k = 0; k < 9; k++) begin : g_lane
    smi_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .n_abs (s6_n[k]),
      .d_abs (s6_d),
      .neg   (s6_neg[k]),
      .zero  (s6_sing),
      .quot  (quot[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_sing[0] <= s6_sing;
      side_det[0]  <= s6_det;
      for (int k = 1; k < LAT; k++) begin
        side_sing[k] <= side_sing[k-1];
        side_det[k]  <= side_det[k-1];
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      for (int k = 0; k < LAT; k++) begin
        side_v[k] <= 1'b0;
      end
      res_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= head_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      s5_v      <= s4_v;
      s6_v      <= s5_v;
      side_v[0] <= s6_v;
      for (int k = 1; k < LAT; k++) begin
        side_v[k] <= side_v[k-1];
      end
      res_valid <= side_v[LAT-1];
    end
  end

  // Result register.
  always_comb begin
    res_d.inv_e0      = quot[0];
    res_d.inv_e1      = quot[1];
    res_d.inv_e2      = quot[2];
    res_d.inv_e3      = quot[3];
    res_d.inv_e4      = quot[4];
    res_d.inv_e5      = quot[5];
    res_d.inv_e6      = quot[6];
    res_d.inv_e7      = quot[7];
    res_d.inv_e8      = quot[8];
    res_d.determinant = side_det[LAT-1];
    res_d.singular    = side_sing[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_d;
    end
  end

  // A singular result carries a zero determinant.
  a_sing_det: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.singular) |-> (res.determinant == '0))
    else $error("singular result with nonzero determinant");

  // A singular result carries an all-zero inverse.
  a_sing_inv: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.singular) |->
      (res.inv_e0 == '0 && res.inv_e1 == '0 && res.inv_e2 == '0 &&
       res.inv_e3 == '0 && res.inv_e4 == '0 && res.inv_e5 == '0 &&
       res.inv_e6 == '0 && res.inv_e7 == '0 && res.inv_e8 == '0))
    else $error("singular result with nonzero inverse");

endmodule

// ===== design/small_matrix_inverse_core.sv =====
// Top level of the 2x2/3x3 matrix inverse core.
//
//   channel  valid      stall      payload  direction
//   mat      mat_valid  mat_stall  mat      in   (size selector and nine elements)
//   res      res_valid  res_stall  res      out  (inverse, determinant, singular flag)
//
// One matrix is taken in every cycle while the queue is not full; the nine divider lanes are fully pipelined.
// A transaction passes through the queue, the arithmetic stages, the one-bit-per-stage
// divider lanes and the result register before its result leaves.
// Reset is synchronous and clears the queue and all stage valid bits.
// A held result freezes the back pipeline; the queue keeps taking matrices until full.
module small_matrix_inverse_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          mat_valid,
  output logic          mat_stall,
  input  smi_pkg::mat_t mat,
  output logic          res_valid,
  input  logic          res_stall,
  output smi_pkg::res_t res
);

  smi_pkg::work_t head;
  logic           head_valid;
  logic           pop;

  // Front: accept and classify.
  smi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mat_valid  (mat_valid),
    .mat_stall  (mat_stall),
    .mat        (mat),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Back: arithmetic pipeline and result register.
  smi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

// ===== test/tb_small_matrix_inverse_core.sv =====
// Self-checking testbench for the 2x2/3x3 matrix inverse core.
module tb_small_matrix_inverse_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           mat_valid = 1'b0;
  logic           mat_stall;
  smi_pkg::mat_t  mat = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  smi_pkg::res_t  res;

  smi_pkg::mat_t  pending_mats[$];
  smi_pkg::res_t  expected_results[$];
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    errors = 0;
  int    cycles = 0;

  small_matrix_inverse_core uut (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Clamp an exact value into a signed field of the given width.
  function automatic logic [63:0] clamp(wide_t v, int bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - 1;
    lo = -(wide_t'(1) <<< (bits - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[63:0];
  endfunction

  // Exact adjugate and determinant, then the rounded and saturated outputs.
  function automatic smi_pkg::res_t inverse_of(smi_pkg::mat_t m);
    wide_t e[9];
    wide_t adj[9];
    wide_t det;
    wide_t q;
    smi_pkg::res_t  r;
    logic [smi_pkg::NELEM-1:0][smi_pkg::DW-1:0] inv;
    logic [63:0] qc;
    int    n;
    e[0] = m.m_e0; e[1] = m.m_e1; e[2] = m.m_e2;
    e[3] = m.m_e3; e[4] = m.m_e4; e[5] = m.m_e5;
    e[6] = m.m_e6; e[7] = m.m_e7; e[8] = m.m_e8;
    for (int i = 0; i < 9; i++) adj[i] = 0;
    inv = '0;
    if (m.action == smi_pkg::MODE_3X3) begin
      adj[0] = e[4]*e[8] - e[5]*e[7];
      adj[1] = e[7]*e[2] - e[8]*e[1];
      adj[2] = e[1]*e[5] - e[2]*e[4];
      adj[3] = e[5]*e[6] - e[3]*e[8];
      adj[4] = e[8]*e[0] - e[6]*e[2];
      adj[5] = e[2]*e[3] - e[0]*e[5];
      adj[6] = e[3]*e[7] - e[4]*e[6];
      adj[7] = e[6]*e[1] - e[7]*e[0];
      adj[8] = e[0]*e[4] - e[1]*e[3];
      det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
      n = 9;
      r.determinant = clamp(det >>> smi_pkg::FB, smi_pkg::DETW);
    end else begin
      adj[0] = e[3];
      adj[1] = -e[1];
      adj[2] = -e[2];
      adj[3] = e[0];
      det = e[0]*e[3] - e[2]*e[1];
      n = 4;
      r.determinant = clamp(det, smi_pkg::DETW);
    end
    if (det != 0) begin
      for (int i = 0; i < n; i++) begin
        q = (adj[i] <<< (2 * smi_pkg::FB)) / det;
        qc = clamp(q, smi_pkg::DW);
        inv[i] = qc[smi_pkg::DW-1:0];
      end
    end
    r.inv_e0 = inv[0]; r.inv_e1 = inv[1]; r.inv_e2 = inv[2];
    r.inv_e3 = inv[3]; r.inv_e4 = inv[4]; r.inv_e5 = inv[5];
    r.inv_e6 = inv[6]; r.inv_e7 = inv[7]; r.inv_e8 = inv[8];
    r.singular = (det == 0);
    return r;
  endfunction

  // Random element: full range, a scaled value, or a small integer.
  function automatic smi_pkg::elem_t rand_elem();
    case ($urandom_range(3))
      0: return $urandom;
      1: return signed'($urandom) >>> $urandom_range(31);
      2: return signed'($urandom_range(0, 8)) - 4 <<< smi_pkg::FB;
      default: return signed'($urandom) >>> $urandom_range(10, 18);
    endcase
  endfunction

  function automatic smi_pkg::mat_t rand_mat();
    smi_pkg::mat_t m;
    m.action = 1'($urandom_range(1));
    m.m_e0 = rand_elem(); m.m_e1 = rand_elem(); m.m_e2 = rand_elem();
    m.m_e3 = rand_elem(); m.m_e4 = rand_elem(); m.m_e5 = rand_elem();
    m.m_e6 = rand_elem(); m.m_e7 = rand_elem(); m.m_e8 = rand_elem();
    // Make some matrices singular by repeating a row.
    if ($urandom_range(7) == 0) begin
      if (m.action == smi_pkg::MODE_3X3) begin
        m.m_e6 = m.m_e0; m.m_e7 = m.m_e1; m.m_e8 = m.m_e2;
      end else begin
        m.m_e2 = m.m_e0; m.m_e3 = m.m_e1;
      end
    end
    return m;
  endfunction

  function automatic smi_pkg::mat_t make_mat(logic three, smi_pkg::elem_t a0,
                                             smi_pkg::elem_t a1, smi_pkg::elem_t a2,
                                             smi_pkg::elem_t a3, smi_pkg::elem_t a4,
                                             smi_pkg::elem_t a5, smi_pkg::elem_t a6,
                                             smi_pkg::elem_t a7, smi_pkg::elem_t a8);
    smi_pkg::mat_t m;
    m.action = three;
    m.m_e0 = a0; m.m_e1 = a1; m.m_e2 = a2; m.m_e3 = a3; m.m_e4 = a4;
    m.m_e5 = a5; m.m_e6 = a6; m.m_e7 = a7; m.m_e8 = a8;
    return m;
  endfunction

  // Driver: present queued matrices, record the expected result on each transaction.
  always @(posedge clk) begin
    if (rst) begin
      mat_valid <= 1'b0;
    end else if (!mat_valid || !mat_stall) begin
      if (mat_valid) expected_results.push_back(inverse_of(mat));
      if (pending_mats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        mat       <= pending_mats.pop_front();
        mat_valid <= 1'b1;
      end else begin
        mat_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    smi_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $realtime, res);
      end else begin
        want = expected_results.pop_front();
        check_field("inv_e0", 64'(want.inv_e0), 64'(res.inv_e0));
        check_field("inv_e1", 64'(want.inv_e1), 64'(res.inv_e1));
        check_field("inv_e2", 64'(want.inv_e2), 64'(res.inv_e2));
        check_field("inv_e3", 64'(want.inv_e3), 64'(res.inv_e3));
        check_field("inv_e4", 64'(want.inv_e4), 64'(res.inv_e4));
        check_field("inv_e5", 64'(want.inv_e5), 64'(res.inv_e5));
        check_field("inv_e6", 64'(want.inv_e6), 64'(res.inv_e6));
        check_field("inv_e7", 64'(want.inv_e7), 64'(res.inv_e7));
        check_field("inv_e8", 64'(want.inv_e8), 64'(res.inv_e8));
        check_field("determinant", want.determinant, res.determinant);
        check_field("singular", 64'(want.singular), 64'(res.singular));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus in three idling phases, draining fully between them.
  initial begin
    smi_pkg::elem_t one;
    smi_pkg::elem_t mx;
    smi_pkg::elem_t mn;
    one = 1 <<< smi_pkg::FB;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: identities, extremes, singular and tiny determinants, ignored inputs.
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, one, 0, 0, one, mx, mn, -1, 5, 7));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, one, 0, 0, 0, one, 0, 0, 0, one));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, mx, mx, mx, mx, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, mn, 0, 0, mn, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, mn, mx, mn, mn, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, mn, 0, 0, 0, mn, 0, 0, 0, mn));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, mx, 0, 0, 0, mx, 0, 0, 0, mx));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, mn, mx, mn, mx, mn, mn, mn, mn, mx));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, 1, 0, 0, 1, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, -1, 0, 0, 1, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, -1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, 1, 2, 3, 4, 5, 6, 7, 8, 9));
    pending_mats.push_back(make_mat(smi_pkg::MODE_3X3, 2*one, one, 0, one, 3*one, one,
                                    0, one, 4*one));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, 3*one, -one, 2*one, 5*one,
                                    0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(smi_pkg::MODE_2X2, one, 2*one, 2*one, 4*one,
                                    1, 1, 1, 1, 1));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 17 : 0;
      for (int i = 0; i < 430; i++) pending_mats.push_back(rand_mat());
      // Hold off until every transaction of this phase has produced its result.
      while (pending_mats.size() > 0 || mat_valid || expected_results.size() > 0)
        @(posedge clk);
    end

    repeat (smi_pkg::DW + 20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
